@@ src/ble_beacon_parse_and_track_macros.svh @@
// Assertion macros shared by the beacon tracker RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BLE_BEACON_PARSE_AND_TRACK_MACROS_SVH
`define BLE_BEACON_PARSE_AND_TRACK_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BBPT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BBPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/bbpt_pkg.sv @@
// Types and constants for the BLE beacon parser and device tracker.
// No dependencies; used by bbpt_parse, bbpt_table and the top level.
package bbpt_pkg;

   // Beacon signature bytes and minimum lengths
   localparam logic [7:0] IB_BYTE0   = 8'h4C;
   localparam logic [7:0] IB_BYTE1   = 8'h00;
   localparam logic [7:0] IB_BYTE2   = 8'h02;
   localparam logic [7:0] IB_BYTE3   = 8'h15;
   localparam logic [7:0] AB_BYTE2   = 8'hBE;
   localparam logic [7:0] AB_BYTE3   = 8'hAC;
   localparam logic [7:0] IB_MIN_LEN = 8'd25;
   localparam logic [7:0] AB_MIN_LEN = 8'd24;

   localparam int SLOT_WIDTH = 6;
   typedef logic [SLOT_WIDTH-1:0] slot_type;

   typedef enum logic [1:0] {
      ACT_UPDATE  = 2'd0,
      ACT_INSERT  = 2'd1,
      ACT_REPLACE = 2'd2,
      ACT_DROP    = 2'd3
   } action_type;

   typedef enum logic {
      KIND_IBEACON   = 1'b0,
      KIND_ALTBEACON = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_HOLD
   } state_type;

   // Table key and stored entry
   typedef struct packed {
      logic [47:0] addr;
      logic [31:0] seen;
   } key_type;

   // Decoded beacon fields carried to the result
   typedef struct packed {
      kind_type           kind;
      logic [63:0]        uuid_high;
      logic [63:0]        uuid_low;
      logic [15:0]        major_id;
      logic [15:0]        minor_id;
      logic signed [7:0]  power_1m;
      logic signed [7:0]  rssi;
   } beacon_type;

   // Table engine status towards the top level
   typedef struct packed {
      logic       idle;
      logic       done;
      action_type action;
      slot_type   slot;
   } table_status_type;

endpackage

@@ src/bbpt_if.sv @@
// Valid/ready channel interfaces for advert requests and tracker responses.
// No dependencies.
interface bbpt_req_if;
   logic              valid;
   logic              ready;
   logic [63:0]       mfg_head;
   logic [63:0]       mfg_mid;
   logic [63:0]       mfg_tail;
   logic [7:0]        mfg_byte24;
   logic [7:0]        mfg_length;
   logic [47:0]       device_addr;
   logic signed [7:0] signal_rssi;
   logic [31:0]       seen_time;

   modport source (
      output valid, mfg_head, mfg_mid, mfg_tail, mfg_byte24, mfg_length,
             device_addr, signal_rssi, seen_time,
      input  ready
   );
   modport sink (
      input  valid, mfg_head, mfg_mid, mfg_tail, mfg_byte24, mfg_length,
             device_addr, signal_rssi, seen_time,
      output ready
   );
endinterface

interface bbpt_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        table_action;
   logic [5:0]        table_slot;
   logic              beacon_kind;
   logic [63:0]       uuid_high;
   logic [63:0]       uuid_low;
   logic [15:0]       major_id;
   logic [15:0]       minor_id;
   logic signed [7:0] tx_power_dbm;
   logic signed [7:0] rssi_out;

   modport source (
      output valid, table_action, table_slot, beacon_kind, uuid_high, uuid_low,
             major_id, minor_id, tx_power_dbm, rssi_out,
      input  ready
   );
   modport sink (
      input  valid, table_action, table_slot, beacon_kind, uuid_high, uuid_low,
             major_id, minor_id, tx_power_dbm, rssi_out,
      output ready
   );
endinterface

@@ src/bbpt_parse.sv @@
// Advert classifier: recognises iBeacon / AltBeacon and captures the fields.
// Depends on bbpt_pkg.
module bbpt_parse (
   input  logic                 clock,
   input  logic                 load,
   input  logic [63:0]          mfg_head,
   input  logic [63:0]          mfg_mid,
   input  logic [63:0]          mfg_tail,
   input  logic [7:0]           mfg_byte24,
   input  logic [7:0]           mfg_length,
   input  logic [47:0]          device_addr,
   input  logic signed [7:0]    signal_rssi,
   input  logic [31:0]          seen_time,
   output logic                 is_beacon,
   output bbpt_pkg::beacon_type beacon_ff,
   output bbpt_pkg::key_type    key_ff
);

   logic                 is_ibeacon;
   logic                 is_altbeacon;
   logic                 has_tx;
   bbpt_pkg::beacon_type beacon_in;
   bbpt_pkg::key_type    key_in;

   always_comb begin
      is_ibeacon = (mfg_length >= bbpt_pkg::IB_MIN_LEN)
                   && (mfg_head[63:56] == bbpt_pkg::IB_BYTE0)
                   && (mfg_head[55:48] == bbpt_pkg::IB_BYTE1)
                   && (mfg_head[47:40] == bbpt_pkg::IB_BYTE2)
                   && (mfg_head[39:32] == bbpt_pkg::IB_BYTE3);
      is_altbeacon = (mfg_length >= bbpt_pkg::AB_MIN_LEN)
                     && (mfg_head[47:40] == bbpt_pkg::AB_BYTE2)
                     && (mfg_head[39:32] == bbpt_pkg::AB_BYTE3);
      is_beacon = is_ibeacon || is_altbeacon;
      // tx byte present only with the full 25 bytes
      has_tx = mfg_length >= bbpt_pkg::IB_MIN_LEN;

      beacon_in.kind      = is_ibeacon ? bbpt_pkg::KIND_IBEACON : bbpt_pkg::KIND_ALTBEACON;
      beacon_in.uuid_high = {mfg_head[31:0], mfg_mid[63:32]};
      beacon_in.uuid_low  = {mfg_mid[31:0], mfg_tail[63:32]};
      beacon_in.major_id  = mfg_tail[31:16];
      beacon_in.minor_id  = mfg_tail[15:0];
      beacon_in.power_1m  = has_tx ? signed'(mfg_byte24) : 8'sd0;
      beacon_in.rssi      = signal_rssi;

      key_in.addr = device_addr;
      key_in.seen = seen_time;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beacon_ff <= beacon_in;
         key_ff    <= key_in;
      end
   end

endmodule

@@ src/bbpt_table.sv @@
// Device table: entry memory, scan sequencer and placement decision.
// Depends on bbpt_pkg and the assertion macro header.
`include "ble_beacon_parse_and_track_macros.svh"

module bbpt_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  bbpt_pkg::key_type          key,
   input  logic                       out_free,
   output bbpt_pkg::table_status_type status
);

   localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW = $clog2(TABLE_DEPTH + 1);

   typedef logic [IdxW-1:0] idx_type;
   typedef logic [CntW-1:0] cnt_type;

   bbpt_pkg::key_type entry_mem [TABLE_DEPTH];

   bbpt_pkg::state_type  state_ff, state_in;
   cnt_type              count_ff, count_in;
   cnt_type              issue_ff, issue_in;
   logic                 rd_valid_ff, rd_valid_in;
   idx_type              rd_slot_ff, rd_slot_in;
   bbpt_pkg::key_type    rd_entry_ff;
   logic                 match_hit_ff, match_hit_in;
   idx_type              match_slot_ff, match_slot_in;
   logic                 min_hit_ff, min_hit_in;
   idx_type              min_slot_ff, min_slot_in;
   logic [31:0]          min_time_ff, min_time_in;
   bbpt_pkg::action_type action_ff, action_in;
   bbpt_pkg::slot_type   slot_ff, slot_in;
   logic                 issuing;
   logic                 wr_en;
   idx_type              wr_slot;

   assign issuing = (state_ff == bbpt_pkg::ST_SCAN) && (issue_ff < count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bbpt_pkg::ST_IDLE;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff      <= issue_in;
      rd_slot_ff    <= rd_slot_in;
      match_hit_ff  <= match_hit_in;
      match_slot_ff <= match_slot_in;
      min_hit_ff    <= min_hit_in;
      min_slot_ff   <= min_slot_in;
      min_time_ff   <= min_time_in;
      action_ff     <= action_in;
      slot_ff       <= slot_in;
   end

   // entry memory, one read and one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_slot] <= key;
      end
      if (issuing) begin
         rd_entry_ff <= entry_mem[issue_ff[IdxW-1:0]];
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      rd_valid_in   = 1'b0;
      rd_slot_in    = rd_slot_ff;
      match_hit_in  = match_hit_ff;
      match_slot_in = match_slot_ff;
      min_hit_in    = min_hit_ff;
      min_slot_in   = min_slot_ff;
      min_time_in   = min_time_ff;
      action_in     = action_ff;
      slot_in       = slot_ff;
      wr_en         = 1'b0;
      wr_slot       = '0;

      unique case (state_ff)
         bbpt_pkg::ST_IDLE: begin
            if (start) begin
               state_in     = bbpt_pkg::ST_SCAN;
               issue_in     = '0;
               match_hit_in = 1'b0;
               min_hit_in   = 1'b0;
               min_time_in  = '1;
            end
         end
         bbpt_pkg::ST_SCAN: begin
            if (issuing) begin
               issue_in    = issue_ff + cnt_type'(1);
               rd_valid_in = 1'b1;
               rd_slot_in  = issue_ff[IdxW-1:0];
            end
            if (rd_valid_ff) begin
               // first address match wins
               if (!match_hit_ff && (rd_entry_ff.addr == key.addr)) begin
                  match_hit_in  = 1'b1;
                  match_slot_in = rd_slot_ff;
               end
               // strict compare keeps the lowest slot on a tie
               if (rd_entry_ff.seen < min_time_ff) begin
                  min_hit_in  = 1'b1;
                  min_slot_in = rd_slot_ff;
                  min_time_in = rd_entry_ff.seen;
               end
            end
            if (!issuing && !rd_valid_ff) begin
               state_in = bbpt_pkg::ST_DECIDE;
            end
         end
         bbpt_pkg::ST_DECIDE: begin
            state_in = bbpt_pkg::ST_HOLD;
            priority if (match_hit_ff) begin
               wr_en     = 1'b1;
               wr_slot   = match_slot_ff;
               action_in = bbpt_pkg::ACT_UPDATE;
               slot_in   = bbpt_pkg::slot_type'(match_slot_ff);
            end else if (count_ff < cnt_type'(TABLE_DEPTH)) begin
               wr_en     = 1'b1;
               wr_slot   = count_ff[IdxW-1:0];
               count_in  = count_ff + cnt_type'(1);
               action_in = bbpt_pkg::ACT_INSERT;
               slot_in   = bbpt_pkg::slot_type'(count_ff[IdxW-1:0]);
            end else if (min_hit_ff) begin
               wr_en     = 1'b1;
               wr_slot   = min_slot_ff;
               action_in = bbpt_pkg::ACT_REPLACE;
               slot_in   = bbpt_pkg::slot_type'(min_slot_ff);
            end else begin
               // full table, every stamp at maximum
               action_in = bbpt_pkg::ACT_DROP;
               slot_in   = '0;
            end
         end
         bbpt_pkg::ST_HOLD: begin
            if (out_free) begin
               state_in = bbpt_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      status.idle   = state_ff == bbpt_pkg::ST_IDLE;
      status.done   = state_ff == bbpt_pkg::ST_HOLD;
      status.action = action_ff;
      status.slot   = slot_ff;
   end

   `BBPT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= cnt_type'(TABLE_DEPTH), "entry count beyond table depth")
   `BBPT_ASSERT_NEXT(a_count_only_on_decide, clock, reset, state_ff != bbpt_pkg::ST_DECIDE, $stable(count_ff), "entry count moved outside placement")
   `BBPT_ASSERT_SAME(a_read_in_scan, clock, reset, rd_valid_ff, state_ff == bbpt_pkg::ST_SCAN, "read data returned outside the scan")

endmodule

@@ src/ble_beacon_parse_and_track.sv @@
// Top level of the BLE beacon parser and device tracker.
// Depends on bbpt_pkg, bbpt_if, bbpt_parse, bbpt_table and the macro header.
//
//  Channel   Direction  Handshake      Beat
//  req_chan  in         valid / ready  one advertisement (bytes, length, addr, RSSI, time)
//  rsp_chan  out        valid / ready  one table result with the decoded beacon fields
//
// A non-beacon advert is taken and gives no beat. A beacon's beat follows
// accept through one read per filled slot, the read return, scan close,
// placement and hand-over; the next advert is taken once back in idle.
// The result register frees the engine while a beat waits; a second result
// holds the engine until rsp_chan drains. Reset clears the fill count, the
// engine state and the valid flags, not the entry memory.
`include "ble_beacon_parse_and_track_macros.svh"

module ble_beacon_parse_and_track #(
   parameter int TABLE_DEPTH = 64
) (
   input logic        clock,
   input logic        reset,
   bbpt_req_if.sink   req_chan,
   bbpt_rsp_if.source rsp_chan
);

   typedef struct packed {
      bbpt_pkg::action_type action;
      bbpt_pkg::slot_type   slot;
      bbpt_pkg::beacon_type beacon;
   } rsp_beat_type;

   logic                       is_beacon;
   logic                       req_accept;
   logic                       start;
   logic                       out_free;
   logic                       rsp_load;
   bbpt_pkg::beacon_type       beacon;
   bbpt_pkg::key_type          key;
   bbpt_pkg::table_status_type tbl_status;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_beat_type               rsp_beat_ff, rsp_beat_in;

   // adverts are taken whenever the table engine is free
   assign req_chan.ready = tbl_status.idle;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign start          = req_accept && is_beacon;

   bbpt_parse u_parse (
      .clock       (clock),
      .load        (req_accept),
      .mfg_head    (req_chan.mfg_head),
      .mfg_mid     (req_chan.mfg_mid),
      .mfg_tail    (req_chan.mfg_tail),
      .mfg_byte24  (req_chan.mfg_byte24),
      .mfg_length  (req_chan.mfg_length),
      .device_addr (req_chan.device_addr),
      .signal_rssi (req_chan.signal_rssi),
      .seen_time   (req_chan.seen_time),
      .is_beacon   (is_beacon),
      .beacon_ff   (beacon),
      .key_ff      (key)
   );

   bbpt_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .key      (key),
      .out_free (out_free),
      .status   (tbl_status)
   );

   // result register: loads a table result when empty or draining this cycle
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_chan.ready;
      rsp_load     = tbl_status.done && out_free;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
      rsp_beat_in  = rsp_beat_ff;
      if (rsp_load) begin
         rsp_beat_in.action = tbl_status.action;
         rsp_beat_in.slot   = tbl_status.slot;
         rsp_beat_in.beacon = beacon;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.table_action = rsp_beat_ff.action;
   assign rsp_chan.table_slot   = rsp_beat_ff.slot;
   assign rsp_chan.beacon_kind  = rsp_beat_ff.beacon.kind;
   assign rsp_chan.uuid_high    = rsp_beat_ff.beacon.uuid_high;
   assign rsp_chan.uuid_low     = rsp_beat_ff.beacon.uuid_low;
   assign rsp_chan.major_id     = rsp_beat_ff.beacon.major_id;
   assign rsp_chan.minor_id     = rsp_beat_ff.beacon.minor_id;
   assign rsp_chan.tx_power_dbm = rsp_beat_ff.beacon.power_1m;
   assign rsp_chan.rssi_out     = rsp_beat_ff.beacon.rssi;

   `BBPT_ASSERT_NEXT(a_beacon_busies, clock, reset, start, !req_chan.ready, "beacon accepted but engine stayed idle")
   `BBPT_ASSERT_NEXT(a_result_lands, clock, reset, rsp_load, rsp_chan.valid, "table result not registered")
   `BBPT_ASSERT_NEXT(a_result_held, clock, reset, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid && $stable(rsp_beat_ff), "waiting beat changed")

endmodule
